FILE: rtl/core/pbavg_pkg.sv
// Shared types and constants of the pixel binning averager.
`default_nettype none

package pbavg_pkg;

   // Payload and register widths
   localparam int PIXEL_W   = 16;
   localparam int SLICE_W   = 10;
   localparam int COORD_W   = 12;
   localparam int SUM_W     = 24;
   localparam int VAL_W     = 25;
   localparam int CSR_W     = 13;
   localparam int FACTOR_W  = 5;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_FACTOR   = 2'd2;

   // Register reset values
   localparam logic [CSR_W-1:0]    WIDTH_RESET  = 13'd512;
   localparam logic [CSR_W-1:0]    HEIGHT_RESET = 13'd512;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd1;

   // Rows per slice never exceed this
   localparam int ROW_LIMIT = 4096;

   // The HU offset of 1024 is a left shift of the bin area by this amount
   localparam int HU_SHIFT = 10;

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef struct packed {
      logic accept;
      logic accumulate;
      logic offset;
      logic div_start;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic produce;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/pbavg_div.sv
// Restoring divider, one quotient bit per cycle, with sign and 25-bit saturation.
`default_nettype none

module pbavg_div #(
   parameter int AW        = 10,
   parameter int SW        = 25,
   parameter int FRAC_BITS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [SW-1:0]                 dividend,
   input  wire logic        [AW-1:0]                 divisor,
   output      logic                                 done,
   output      logic signed [pbavg_pkg::VAL_W-1:0]   value
);
   import pbavg_pkg::*;

   localparam int MW   = SW - 1;
   localparam int DW   = MW + FRAC_BITS;
   localparam int CNTW = $clog2(DW + 1);
   localparam int XW   = DW + 2;
   localparam logic [XW-1:0] POS_LIM = XW'(2**(VAL_W-1) - 1);
   localparam logic [XW-1:0] NEG_LIM = XW'(2**(VAL_W-1));

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]           rem_ff, rem_in;
   logic [DW-1:0]           quo_ff, quo_in;
   logic                    neg_ff, neg_in;
   logic signed [VAL_W-1:0] value_ff, value_in;

   logic signed [SW-1:0] neg_dividend;
   logic [MW-1:0]        mag;
   logic [AW:0]          shifted;
   logic [AW+1:0]        diff;
   logic [XW-1:0]        quo_x;
   logic [XW-1:0]        quo_neg;

   always_comb begin
      neg_dividend = -dividend;
      mag          = MW'(dividend[SW-1] ? neg_dividend : dividend);
      shifted      = {rem_ff, quo_ff[DW-1]};
      diff         = {1'b0, shifted} - {2'b00, divisor};
      quo_x        = XW'(quo_ff);
      quo_neg      = -quo_x;

      busy_in  = busy_ff;
      done_in  = done_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      value_in = value_ff;

      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNTW'(DW);
         rem_in  = '0;
         quo_in  = DW'(mag) << FRAC_BITS;
         neg_in  = dividend[SW-1];
      end else if (busy_ff && cnt_ff != '0) begin
         cnt_in = cnt_ff - CNTW'(1);
         if (!diff[AW+1]) begin
            rem_in = diff[AW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[AW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
      end else if (busy_ff) begin
         // apply sign and saturate to the output format
         busy_in = 1'b0;
         done_in = 1'b1;
         if (neg_ff) begin
            value_in = (quo_x > NEG_LIM) ? VAL_MIN : VAL_W'(quo_neg);
         end else begin
            value_in = (quo_x > POS_LIM) ? VAL_MAX : VAL_W'(quo_x);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      value_ff <= value_in;
   end

   assign done  = done_ff;
   assign value = value_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

`default_nettype wire

FILE: rtl/core/pbavg_ctrl.sv
// Sequencer that steps each pixel through accumulate and, for a pixel that closes a bin, offset, divide and output.
`default_nettype none

module pbavg_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire pbavg_pkg::dp_status_type status,
   output      pbavg_pkg::ctrl_cmd_type  cmd
);
   import pbavg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_OFS,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stall_ff) begin
               cmd.accept = 1'b1;
               state_in   = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = status.produce ? ST_OFS : ST_IDLE;
         end
         ST_OFS: begin
            cmd.offset = 1'b1;
            state_in   = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               if (status.out_free) begin
                  cmd.load_out = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            // hold until the previous result transfer frees the output register
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      stall_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> req_stall)
      else $error("pixel accepted without stalling the next one");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded over a pending transfer");

   a_open_only_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == ST_IDLE)
      else $error("input open outside idle");

endmodule

`default_nettype wire

FILE: rtl/core/pbavg_dp.sv
// Datapath: registers, raster counters, column-sum store, divider and result registers.
`default_nettype none

module pbavg_dp #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_BIN   = 16,
   parameter int FRAC_BITS = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic        [pbavg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [pbavg_pkg::CSR_W-1:0]     csr_wdata,
   input  wire logic        [pbavg_pkg::PIXEL_W-1:0]   req_pixel,
   input  wire logic        [pbavg_pkg::SLICE_W-1:0]   req_slice_index,
   input  wire pbavg_pkg::ctrl_cmd_type                cmd,
   output      pbavg_pkg::dp_status_type               status,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic signed [pbavg_pkg::VAL_W-1:0]     rsp_bin_value,
   output      logic        [pbavg_pkg::COORD_W-1:0]   rsp_bin_column,
   output      logic        [pbavg_pkg::COORD_W-1:0]   rsp_bin_row,
   output      logic        [pbavg_pkg::SLICE_W-1:0]   rsp_bin_slice,
   output      logic signed [pbavg_pkg::VAL_W-1:0]     rsp_running_min,
   output      logic signed [pbavg_pkg::VAL_W-1:0]     rsp_running_max
);
   import pbavg_pkg::*;

   localparam int CLW  = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int BW   = $clog2(MAX_BIN + 1);
   localparam int IW   = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;
   localparam int AW   = 2 * BW;
   localparam int SW   = ((SUM_W > AW + HU_SHIFT) ? SUM_W : AW + HU_SHIFT) + 1;
   localparam int FW   = (BW > FACTOR_W) ? BW : FACTOR_W;
   localparam int XWW  = (WW > CSR_W) ? WW : CSR_W;
   localparam int PCW  = (CLW + 1 > WW) ? CLW + 1 : WW;
   localparam int BCW  = (IW + 1 > BW) ? IW + 1 : BW;
   localparam int CPW  = (COORD_W + 1 + BW > WW) ? COORD_W + 1 + BW : WW;
   localparam int RPW  = COORD_W + 1 + BW;

   // Configuration registers
   logic [CSR_W-1:0]    width_ff;
   logic [CSR_W-1:0]    height_ff;
   logic [FACTOR_W-1:0] factor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         factor_ff <= FACTOR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_BIN_FACTOR:   factor_ff <= csr_wdata[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective limits: zero acts as one, oversized values clamp
   logic [XWW-1:0]   wid_x;
   logic [FW-1:0]    fac_x;
   logic [WW-1:0]    w;
   logic [CSR_W-1:0] h;
   logic [BW-1:0]    b;

   always_comb begin
      wid_x = XWW'(width_ff);
      fac_x = FW'(factor_ff);
      if (wid_x == '0)                   w = WW'(1);
      else if (wid_x > XWW'(MAX_WIDTH))  w = WW'(MAX_WIDTH);
      else                               w = WW'(wid_x);
      if (height_ff == '0)                   h = CSR_W'(1);
      else if (height_ff > CSR_W'(ROW_LIMIT)) h = CSR_W'(ROW_LIMIT);
      else                                    h = height_ff;
      if (fac_x == '0)                  b = BW'(1);
      else if (fac_x > FW'(MAX_BIN))    b = BW'(MAX_BIN);
      else                              b = BW'(fac_x);
   end

   // Raster counters
   logic [CLW-1:0]     pixel_col_ff, pixel_col_in;
   logic [COORD_W-1:0] pixel_row_ff, pixel_row_in;
   logic [IW-1:0]      col_in_bin_ff, col_in_bin_in;
   logic [IW-1:0]      row_in_band_ff, row_in_band_in;
   logic [COORD_W-1:0] bin_col_ff, bin_col_in;
   logic [COORD_W-1:0] bin_row_ff, bin_row_in;

   logic [BCW-1:0]     cib_p1, rib_p1, b_x;
   logic [PCW-1:0]     pc_p1;
   logic [COORD_W:0]   pr_p1;
   logic [COORD_W:0]   bc_p1, br_p1;
   logic [CPW-1:0]     col_prod;
   logic [RPW-1:0]     row_prod;
   logic               in_col, in_row, first, last;

   always_comb begin
      b_x    = BCW'(b);
      cib_p1 = BCW'(col_in_bin_ff) + BCW'(1);
      rib_p1 = BCW'(row_in_band_ff) + BCW'(1);
      pc_p1  = PCW'(pixel_col_ff) + PCW'(1);
      pr_p1  = {1'b0, pixel_row_ff} + (COORD_W+1)'(1);
      bc_p1  = {1'b0, bin_col_ff} + (COORD_W+1)'(1);
      br_p1  = {1'b0, bin_row_ff} + (COORD_W+1)'(1);

      // bin index below limit/b  <=>  (index+1)*b <= limit
      col_prod = CPW'(bc_p1) * CPW'(b);
      row_prod = RPW'(br_p1) * RPW'(b);
      in_col   = (col_prod <= CPW'(w)) && (CPW'(bin_col_ff) < CPW'(MAX_WIDTH));
      in_row   = (row_prod <= RPW'(h));
      first    = (row_in_band_ff == '0) && (col_in_bin_ff == '0);
      last     = (rib_p1 >= b_x) && (cib_p1 >= b_x);

      col_in_bin_in  = IW'(cib_p1);
      bin_col_in     = bin_col_ff;
      pixel_col_in   = CLW'(pc_p1);
      row_in_band_in = row_in_band_ff;
      bin_row_in     = bin_row_ff;
      pixel_row_in   = pixel_row_ff;
      if (cib_p1 >= b_x) begin
         col_in_bin_in = '0;
         bin_col_in    = bc_p1[COORD_W-1:0];
      end
      if (pc_p1 >= PCW'(w)) begin
         pixel_col_in   = '0;
         col_in_bin_in  = '0;
         bin_col_in     = '0;
         row_in_band_in = IW'(rib_p1);
         if (rib_p1 >= b_x) begin
            row_in_band_in = '0;
            bin_row_in     = br_p1[COORD_W-1:0];
         end
         pixel_row_in = pr_p1[COORD_W-1:0];
         if (pr_p1 >= h) begin
            pixel_row_in   = '0;
            row_in_band_in = '0;
            bin_row_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_col_ff   <= '0;
         pixel_row_ff   <= '0;
         col_in_bin_ff  <= '0;
         row_in_band_ff <= '0;
         bin_col_ff     <= '0;
         bin_row_ff     <= '0;
      end else if (cmd.accept) begin
         pixel_col_ff   <= pixel_col_in;
         pixel_row_ff   <= pixel_row_in;
         col_in_bin_ff  <= col_in_bin_in;
         row_in_band_ff <= row_in_band_in;
         bin_col_ff     <= bin_col_in;
         bin_row_ff     <= bin_row_in;
      end
   end

   // Per-pixel work registers
   logic [PIXEL_W-1:0] pix_ff;
   logic [SLICE_W-1:0] slice_ff;
   logic [COORD_W-1:0] item_col_ff, item_row_ff;
   logic [CLW-1:0]     addr_ff;
   logic               first_ff;
   logic               in_bin_ff;
   logic               last_ff;
   logic [AW-1:0]      area_ff;
   logic [SUM_W-1:0]   rd_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [SW-1:0] ofs_ff, ofs_in;
   logic [AW+HU_SHIFT-1:0] offset;

   logic [SUM_W-1:0] sums_mem [MAX_WIDTH];

   always_comb begin
      sum_in = first_ff ? SUM_W'(pix_ff) : rd_ff + SUM_W'(pix_ff);
      offset = (AW+HU_SHIFT)'(area_ff) << HU_SHIFT;
      ofs_in = $signed(SW'(sum_ff)) - $signed(SW'(offset));
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ff       <= sums_mem[CLW'(bin_col_ff)];
         pix_ff      <= req_pixel;
         slice_ff    <= req_slice_index;
         item_col_ff <= bin_col_ff;
         item_row_ff <= bin_row_ff;
         addr_ff     <= CLW'(bin_col_ff);
         first_ff    <= first;
         last_ff     <= last;
         area_ff     <= AW'(b) * AW'(b);
      end
      if (cmd.accumulate && in_bin_ff) begin
         sums_mem[addr_ff] <= sum_in;
      end
      if (cmd.accumulate) begin
         sum_ff <= sum_in;
      end
      if (cmd.offset) begin
         ofs_ff <= ofs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_bin_ff <= 1'b0;
      end else if (cmd.accept) begin
         in_bin_ff <= in_col && in_row;
      end
   end

   // Mean of the bin
   logic                    div_done;
   logic signed [VAL_W-1:0] div_value;

   pbavg_div #(
      .AW        (AW),
      .SW        (SW),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (ofs_ff),
      .divisor  (area_ff),
      .done     (div_done),
      .value    (div_value)
   );

   // Result registers and running extremes
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] value_ff;
   logic [COORD_W-1:0]      out_col_ff, out_row_ff;
   logic [SLICE_W-1:0]      out_slice_ff;
   logic signed [VAL_W-1:0] min_ff, min_in;
   logic signed [VAL_W-1:0] max_ff, max_in;

   always_comb begin
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
      min_in       = (div_value < min_ff) ? div_value : min_ff;
      max_in       = (div_value > max_ff) ? div_value : max_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         min_ff       <= VAL_MAX;
         max_ff       <= VAL_MIN;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load_out) begin
            min_ff <= min_in;
            max_ff <= max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         value_ff     <= div_value;
         out_col_ff   <= item_col_ff;
         out_row_ff   <= item_row_ff;
         out_slice_ff <= slice_ff;
      end
   end

   assign status.produce  = in_bin_ff && last_ff;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bin_value   = value_ff;
   assign rsp_bin_column  = out_col_ff;
   assign rsp_bin_row     = out_row_ff;
   assign rsp_bin_slice   = out_slice_ff;
   assign rsp_running_min = min_ff;
   assign rsp_running_max = max_ff;

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> min_ff <= max_ff)
      else $error("running minimum above running maximum");

   a_value_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (value_ff >= min_ff) && (value_ff <= max_ff))
      else $error("bin value outside running extremes");

endmodule

`default_nettype wire

FILE: rtl/core/pixel_bin_average_hu.sv
// Pixel binning averager: a pixel that closes no bin passes accept and accumulate, then the next
// pixel may be accepted. A pixel that closes a bin also passes offset, divide and output, and the
// next pixel is stalled until its result is loaded. The divider retiring one quotient bit per cycle
// over 24+FRAC_BITS bits bounds such pixels; other pixels are bound by the column-sum store read.
// Reset clears counters and extremes and loads width 512, height 512, bin factor 1; the
// column-sum store is not cleared and needs no clearing pass.
`default_nettype none

module pixel_bin_average_hu #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_BIN   = 16,
   parameter int FRAC_BITS = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic        [pbavg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [pbavg_pkg::CSR_W-1:0]     csr_wdata,
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic        [pbavg_pkg::PIXEL_W-1:0]   req_pixel,
   input  wire logic        [pbavg_pkg::SLICE_W-1:0]   req_slice_index,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic signed [pbavg_pkg::VAL_W-1:0]     rsp_bin_value,
   output      logic        [pbavg_pkg::COORD_W-1:0]   rsp_bin_column,
   output      logic        [pbavg_pkg::COORD_W-1:0]   rsp_bin_row,
   output      logic        [pbavg_pkg::SLICE_W-1:0]   rsp_bin_slice,
   output      logic signed [pbavg_pkg::VAL_W-1:0]     rsp_running_min,
   output      logic signed [pbavg_pkg::VAL_W-1:0]     rsp_running_max
);
   import pbavg_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   pbavg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pbavg_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BIN   (MAX_BIN),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_pixel       (req_pixel),
      .req_slice_index (req_slice_index),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_bin_value   (rsp_bin_value),
      .rsp_bin_column  (rsp_bin_column),
      .rsp_bin_row     (rsp_bin_row),
      .rsp_bin_slice   (rsp_bin_slice),
      .rsp_running_min (rsp_running_min),
      .rsp_running_max (rsp_running_max)
   );

endmodule

`default_nettype wire
